// ===== rtl/rss_pkg.sv =====
// Package for the region scanline span block: sizes and action codes.
// No dependencies.
package rss_pkg;
  localparam int MaxRectsDefault = 16;
  localparam int CoordBitsDefault = 16;
  localparam int FieldBits = 16;
  localparam int CountBits = 5;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_OFFSET = 2'd2,
    ACT_QUERY  = 2'd3
  } action_t;
endpackage

// ===== rtl/rss_front.sv =====
// Front end of the region scanline span block: a two-entry command
// queue. Depends on rss_pkg.
module rss_front #(
  parameter int CMD_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [CMD_BITS-1:0] cmd_in,
  output logic                cmd_valid,
  input  logic                cmd_take,
  output logic [CMD_BITS-1:0] cmd_out
);
  import rss_pkg::*;

  logic [CMD_BITS-1:0] slot [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] fill;
  logic do_push, do_pop;

  assign full = (fill == 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd_out = slot[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= cmd_in;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule

// ===== rtl/rss_back.sv =====
// Back end of the region scanline span block: rectangle table, span
// list and the sequencer that carries out each command. Depends on rss_pkg.
module rss_back #(
  parameter int MAX_RECTS = 16,
  parameter int COORD_BITS = 16,
  parameter int CMD_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_take,
  input  logic [CMD_BITS-1:0]           cmd,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [rss_pkg::FieldBits-1:0] span_start,
  output logic signed [rss_pkg::FieldBits-1:0] span_end,
  output logic                          span_valid,
  output logic                          last,
  output logic [rss_pkg::CountBits-1:0] rect_count,
  output logic                          dropped
);
  import rss_pkg::*;

  localparam int IdxBits = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CntBits = $clog2(MAX_RECTS + 1);
  localparam int W = COORD_BITS;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_OFFSET = 7'b0000010,
    ST_QRD    = 7'b0000100,
    ST_QTEST  = 7'b0001000,
    ST_QMERGE = 7'b0010000,
    ST_EMIT   = 7'b0100000,
    ST_OUT    = 7'b1000000
  } state_t;

  state_t state;
  logic [4*W-1:0] rect_mem [MAX_RECTS];
  logic [2*W-1:0] span_mem [MAX_RECTS];
  logic [CntBits-1:0] rect_used, span_used, ri, sj;
  logic [4*W-1:0] rect_rd;
  logic [2*W-1:0] span_rd;
  logic signed [W-1:0] cur_lo, cur_hi;
  logic signed [W-1:0] q_line, q_ws, q_we, dx, dy;
  logic q_win;
  logic out_full;
  logic [1:0] act, cur_act;
  logic signed [W-1:0] rl, rt, rr, rb, tl, th, clo, chi;

  // Command fields, packed as in the top level.
  assign act = cmd[CMD_BITS-1 -: 2];
  assign cmd_take = (state == ST_IDLE) && !out_full;
  assign empty = !out_full;

  assign rl = rect_rd[4*W-1 -: W];
  assign rt = rect_rd[3*W-1 -: W];
  assign rr = rect_rd[2*W-1 -: W];
  assign rb = rect_rd[W-1:0];
  assign tl = span_rd[2*W-1 -: W];
  assign th = span_rd[W-1:0];

  always_comb begin
    clo = rl;
    chi = rr;
    if (q_win) begin
      if (q_ws > rl) clo = q_ws;
      if (q_we < rr) chi = q_we;
    end
  end

  always_ff @(posedge clk) begin
    rect_rd <= rect_mem[ri[IdxBits-1:0]];
    // The span being shown must stay put while the result waits for pop.
    if (!(state == ST_EMIT && out_full && !pop)) begin
      span_rd <= span_mem[sj[IdxBits-1:0]];
    end
    if (rst) begin
      state <= ST_IDLE;
      rect_used <= '0;
      span_used <= '0;
      out_full <= 1'b0;
      ri <= '0;
      sj <= '0;
    end else begin
      if (pop && out_full) out_full <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid && !out_full) begin
            ri <= '0;
            sj <= '0;
            cur_act <= act;
            dx <= cmd[8*W+1 +: W];
            dy <= cmd[7*W+1 +: W];
            q_line <= cmd[6*W+1 +: W];
            q_win <= cmd[6*W];
            q_ws <= cmd[5*W +: W];
            q_we <= cmd[4*W +: W];
            span_valid <= 1'b0;
            span_start <= '0;
            span_end <= '0;
            last <= 1'b1;
            dropped <= 1'b0;
            case (act)
              ACT_ADD: begin
                if (rect_used < CntBits'(MAX_RECTS)) begin
                  rect_mem[rect_used[IdxBits-1:0]] <= cmd[0 +: 4*W];
                  rect_used <= rect_used + 1'b1;
                  rect_count <= CountBits'(rect_used + 1'b1);
                end else begin
                  dropped <= 1'b1;
                  rect_count <= CountBits'(rect_used);
                end
                out_full <= 1'b1;
              end
              ACT_CLEAR: begin
                rect_used <= '0;
                rect_count <= '0;
                out_full <= 1'b1;
              end
              ACT_OFFSET: begin
                rect_count <= CountBits'(rect_used);
                state <= ST_OFFSET;
              end
              default: begin
                rect_count <= CountBits'(rect_used);
                span_used <= '0;
                state <= ST_QRD;
              end
            endcase
          end
        end
        // Offset: read an entry, then write it back shifted.
        ST_OFFSET: begin
          if (ri == rect_used) begin
            out_full <= 1'b1;
            state <= ST_IDLE;
          end else begin
            state <= ST_QTEST;
          end
        end
        ST_QRD: begin
          if (ri == rect_used) begin
            sj <= '0;
            state <= ST_EMIT;
          end else begin
            state <= ST_QTEST;
          end
        end
        ST_QTEST: begin
          if (cur_act == ACT_OFFSET) begin
            rect_mem[ri[IdxBits-1:0]] <= {rl + dx, rt + dy, rr + dx, rb + dy};
            ri <= ri + 1'b1;
            state <= ST_OFFSET;
          end else if (!(q_line >= rt && q_line < rb) || (q_win && clo >= chi)) begin
            ri <= ri + 1'b1;
            state <= ST_QRD;
          end else begin
            cur_lo <= clo;
            cur_hi <= chi;
            sj <= '0;
            state <= ST_QMERGE;
          end
        end
        // Each stored span is addressed in ST_QMERGE, then compared in ST_OUT.
        ST_QMERGE: begin
          if (sj == span_used) begin
            if (span_used < CntBits'(MAX_RECTS)) begin
              span_mem[span_used[IdxBits-1:0]] <= {cur_lo, cur_hi};
              span_used <= span_used + 1'b1;
            end
            ri <= ri + 1'b1;
            state <= ST_QRD;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!(cur_lo > th || cur_hi < tl)) begin
            span_mem[sj[IdxBits-1:0]] <= {(cur_lo < tl) ? cur_lo : tl,
                                          (cur_hi > th) ? cur_hi : th};
            ri <= ri + 1'b1;
            state <= ST_QRD;
          end else begin
            sj <= sj + 1'b1;
            state <= ST_QMERGE;
          end
        end
        ST_EMIT: begin
          if (!out_full || pop) begin
            if (span_used == '0) begin
              out_full <= 1'b1;
              state <= ST_IDLE;
            end else if (sj != '0) begin
              span_start <= FieldBits'(span_rd[2*W-1 -: W]);
              span_end <= FieldBits'(span_rd[W-1:0]);
              span_valid <= 1'b1;
              last <= (sj == span_used);
              out_full <= 1'b1;
              if (sj == span_used) state <= ST_IDLE;
              else sj <= sj + 1'b1;
            end else begin
              sj <= sj + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/region_scanline_spans.sv =====
// Top level of the region scanline span block: packs the input fields
// into a command and joins rss_front and rss_back. Depends on rss_pkg.
//
//   channel | handshake  | payload
//   input   | push, full | action, rect_*, shift_*, scan_line, use_window, win_*
//   result  | empty, pop | span_start, span_end, span_valid, last, rect_count, dropped
//
// Add and clear finish in the idle state; offset reads and writes back
// each stored rectangle. A query tests each rectangle, compares it with
// the stored spans and merges or appends it, then emits each span as one
// result, or one empty result if there is none.
// Reset clears the counts and queues; table contents stay undefined.
// A stalled result holds the back end; the front queue keeps taking
// up to two commands meanwhile.
module region_scanline_spans #(
  parameter int MAX_RECTS = rss_pkg::MaxRectsDefault,
  parameter int COORD_BITS = rss_pkg::CoordBitsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [1:0] action,
  input  logic signed [rss_pkg::FieldBits-1:0] rect_left,
  input  logic signed [rss_pkg::FieldBits-1:0] rect_top,
  input  logic signed [rss_pkg::FieldBits-1:0] rect_right,
  input  logic signed [rss_pkg::FieldBits-1:0] rect_bottom,
  input  logic signed [rss_pkg::FieldBits-1:0] shift_x,
  input  logic signed [rss_pkg::FieldBits-1:0] shift_y,
  input  logic signed [rss_pkg::FieldBits-1:0] scan_line,
  input  logic use_window,
  input  logic signed [rss_pkg::FieldBits-1:0] win_start,
  input  logic signed [rss_pkg::FieldBits-1:0] win_end,
  output logic empty,
  input  logic pop,
  output logic signed [rss_pkg::FieldBits-1:0] span_start,
  output logic signed [rss_pkg::FieldBits-1:0] span_end,
  output logic span_valid,
  output logic last,
  output logic [rss_pkg::CountBits-1:0] rect_count,
  output logic dropped
);
  import rss_pkg::*;

  localparam int W = COORD_BITS;
  localparam int CmdBits = 9 * W + 3;

  logic [CmdBits-1:0] cmd_in, cmd_q;
  logic cmd_valid, cmd_take;

  function automatic logic [W-1:0] sx(input logic [FieldBits-1:0] v);
    logic [W+FieldBits-1:0] e;
    e = {{W{v[FieldBits-1]}}, v};
    return e[W-1:0];
  endfunction

  assign cmd_in = {action, sx(shift_x), sx(shift_y), sx(scan_line), use_window,
                   sx(win_start), sx(win_end),
                   sx(rect_left), sx(rect_top), sx(rect_right), sx(rect_bottom)};

  rss_front #(.CMD_BITS(CmdBits)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .cmd_in(cmd_in),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd_out(cmd_q)
  );

  rss_back #(.MAX_RECTS(MAX_RECTS), .COORD_BITS(COORD_BITS), .CMD_BITS(CmdBits)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd_q),
    .empty(empty), .pop(pop), .span_start(span_start), .span_end(span_end),
    .span_valid(span_valid), .last(last), .rect_count(rect_count), .dropped(dropped)
  );
endmodule

// ===== rtl/rss_checker.sv =====
// Port-level checks for region_scanline_spans, bound to the top level.
// Depends on rss_pkg.
module rss_checker (
  input logic clk,
  input logic rst,
  input logic empty,
  input logic pop,
  input logic span_valid,
  input logic last,
  input logic dropped,
  input logic [rss_pkg::CountBits-1:0] rect_count
);
  import rss_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(rect_count)))
    else $error("result changed while stalled");
  a_drop: assert property (@(posedge clk) disable iff (rst)
    (!empty && dropped) |-> (!span_valid && last))
    else $error("drop flag on a span result");
  a_novalid: assert property (@(posedge clk) disable iff (rst)
    (!empty && !span_valid) |-> last)
    else $error("empty result not last");
  a_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result after reset");
endmodule

bind region_scanline_spans rss_checker u_rss_checker (
  .clk(clk), .rst(rst), .empty(empty), .pop(pop), .span_valid(span_valid),
  .last(last), .dropped(dropped), .rect_count(rect_count)
);

// ===== bench/tb.sv =====
// Testbench for region_scanline_spans: drives add, clear, offset and query
// transactions and checks every result against an in-bench region model.
// Depends on rss_pkg and the region_scanline_spans RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rss_pkg::*;

  localparam int NumRects = 16;

  typedef struct packed {
    logic signed [15:0] span_start;
    logic signed [15:0] span_end;
    logic span_valid;
    logic last;
    logic [4:0] rect_count;
    logic dropped;
  } span_rec_t;

  typedef struct {
    logic signed [15:0] left, top, right, bottom;
  } box_t;

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic pop = 0;
  logic [1:0] action = '0;
  logic signed [15:0] rect_left = '0, rect_top = '0, rect_right = '0, rect_bottom = '0;
  logic signed [15:0] shift_x = '0, shift_y = '0, scan_line = '0;
  logic use_window = 0;
  logic signed [15:0] win_start = '0, win_end = '0;
  logic full, empty, span_valid, last, dropped;
  logic signed [15:0] span_start, span_end;
  logic [4:0] rect_count;

  box_t boxes[NumRects];
  int box_count = 0;
  span_rec_t expected_spans[$];
  int fail_count = 0;
  bit pop_enable = 0;

  region_scanline_spans u_dut (.*);

  always #5 clk = ~clk;

  // Updates the region and queues the results one transaction should give.
  task automatic predict_region(input action_t act);
    int lo[NumRects], hi[NumRects];
    int used, l, h, line;
    bit merged;
    span_rec_t r;
    r = '0;
    r.last = 1;
    case (act)
      ACT_ADD: begin
        if (box_count < NumRects) begin
          boxes[box_count] = '{rect_left, rect_top, rect_right, rect_bottom};
          box_count++;
        end else begin
          r.dropped = 1;
        end
      end
      ACT_CLEAR: box_count = 0;
      ACT_OFFSET: begin
        for (int i = 0; i < box_count; i++) begin
          boxes[i].left += shift_x;
          boxes[i].right += shift_x;
          boxes[i].top += shift_y;
          boxes[i].bottom += shift_y;
        end
      end
      default: begin
        used = 0;
        line = scan_line;
        for (int i = 0; i < box_count; i++) begin
          if (line < int'(boxes[i].top) || line >= int'(boxes[i].bottom)) continue;
          l = boxes[i].left;
          h = boxes[i].right;
          if (use_window) begin
            if (int'(win_start) > l) l = win_start;
            if (int'(win_end) < h) h = win_end;
            if (l >= h) continue;
          end
          merged = 0;
          for (int j = 0; j < used; j++) begin
            if (!(l > hi[j] || h < lo[j])) begin
              if (l < lo[j]) lo[j] = l;
              if (h > hi[j]) hi[j] = h;
              merged = 1;
              break;
            end
          end
          if (!merged) begin
            lo[used] = l;
            hi[used] = h;
            used++;
          end
        end
        for (int j = 0; j < used; j++) begin
          r.span_start = 16'(lo[j]);
          r.span_end = 16'(hi[j]);
          r.span_valid = 1;
          r.last = (j == used - 1);
          r.rect_count = 5'(box_count);
          expected_spans.push_back(r);
        end
        if (used > 0) return;
      end
    endcase
    r.rect_count = 5'(box_count);
    expected_spans.push_back(r);
  endtask

  // Sends one transaction after a random gap and predicts its results.
  // Push stays high after the accepting edge until the next falling edge.
  task automatic send_item(input action_t act, input int a, b, c, d,
                           input bit win = 1'b0, input int ws = 0, we = 0);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      @(negedge clk);
      push <= 0;
    end
    @(negedge clk);
    push <= 1;
    action <= act;
    rect_left <= 16'(a); rect_top <= 16'(b); rect_right <= 16'(c); rect_bottom <= 16'(d);
    shift_x <= 16'(a); shift_y <= 16'(b); scan_line <= 16'(c);
    use_window <= win; win_start <= 16'(ws); win_end <= 16'(we);
    @(posedge clk);
    while (full) @(posedge clk);
    predict_region(act);
  endtask

  task automatic drain_results();
    int guard;
    @(negedge clk);
    push <= 0;
    guard = 0;
    while (expected_spans.size() > 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (!pop_enable) pop <= 0;
    else if ($urandom_range(0, 19) == 0) pop <= 0;
    else if (!pop) pop <= ($urandom_range(0, 2) != 0);
  end

  always @(posedge clk) begin
    span_rec_t got, want;
    if (!rst && pop && !empty) begin
      got = '{span_start, span_end, span_valid, last, rect_count, dropped};
      if (expected_spans.size() == 0) begin
        $display("%0t: result with none expected: %p", $time, got);
        fail_count++;
      end else begin
        want = expected_spans.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, got);
          fail_count++;
        end
      end
    end
  end

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 40) - 20);
    endcase
  endfunction

  task automatic test_extremes();
    send_item(ACT_QUERY, 0, 0, 0, 0);
    send_item(ACT_ADD, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_item(ACT_ADD, 10, 0, 5, 10);
    send_item(ACT_ADD, 5, 0, 12, 10);
    send_item(ACT_QUERY, 0, 0, 3, 0);
    send_item(ACT_QUERY, 0, 0, 3, 0, 1'b1, 6, 11);
    send_item(ACT_QUERY, 0, 0, 3, 0, 1'b1, 11, 6);
    send_item(ACT_QUERY, 0, 0, 16'h8000, 0, 1'b1, 16'h8000, 16'h7fff);
    send_item(ACT_OFFSET, 16'h7fff, 16'h8000, 0, 0);
    send_item(ACT_QUERY, 0, 0, 16'h7fff, 0);
    send_item(ACT_CLEAR, 0, 0, 0, 0);
    send_item(ACT_QUERY, 0, 0, 0, 0);
  endtask

  task automatic test_full_table();
    for (int i = 0; i < NumRects + 2; i++)
      send_item(ACT_ADD, i * 3, 0, i * 3 + (i % 3), 4);
    send_item(ACT_QUERY, 0, 0, 1, 0);
    send_item(ACT_CLEAR, 0, 0, 0, 0);
  endtask

  task automatic test_random();
    for (int n = 0; n < 300; n++) begin
      case ($urandom_range(0, 9))
        0: send_item(ACT_CLEAR, 0, 0, 0, 0);
        1: send_item(ACT_OFFSET, rand_coord(), rand_coord(), 0, 0);
        2, 3, 4: send_item(ACT_ADD, rand_coord(), rand_coord(), rand_coord(), rand_coord());
        default: send_item(ACT_QUERY, 0, 0, rand_coord(), 0, 1'($urandom_range(0, 1)),
                           rand_coord(), rand_coord());
      endcase
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    pop_enable = 1;
    test_extremes();
    test_full_table();
    test_random();
    drain_results();
    if (fail_count == 0 && expected_spans.size() == 0) $display("[region_scanline_spans] OK");
    else $display("[region_scanline_spans] ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("[region_scanline_spans] ERROR");
    $finish;
  end
endmodule
